// ===== src/tsq_pkg.sv =====
package tsq_pkg;

    localparam int SAMPLES_PER_AXIS_DEF = 10;
    localparam int TRIM_EACH_END_DEF    = 2;

    localparam int SAMPLE_W = 12;
    localparam int POS_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AGREE_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd5;

    localparam logic [POS_W-1:0] NO_TOUCH = 16'hFFFF;

    // Control carried from the sequencer into every sorting cell.
    typedef struct packed {
        logic insert;  // a new sample enters the chain this cycle
        logic clear;   // empty the chain before the next group
        logic shift;   // drain: every cell takes its left neighbor
    } cell_ctrl_t;

endpackage

// ===== src/tsq_sort_cell.sv =====
// One cell of an insertion-sorting chain. Cells hold values in ascending order;
// empty cells sit at the high end. On insert, a cell keeps its value, takes the new
// value, or takes its left neighbor's value.
module tsq_sort_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tsq_pkg::cell_ctrl_t          ctrl,
    input  logic [tsq_pkg::SAMPLE_W-1:0] new_val,
    input  logic [tsq_pkg::SAMPLE_W-1:0] left_val,
    input  logic                         left_full,
    input  logic                         left_moves,
    output logic [tsq_pkg::SAMPLE_W-1:0] val,
    output logic                         full,
    output logic                         moves
);
    logic [tsq_pkg::SAMPLE_W-1:0] val_reg, val_next;
    logic                         full_reg, full_next;

    // This cell is displaced when it is empty or holds a larger value.
    assign moves = !full_reg || (val_reg > new_val);

    always_comb
    begin
        val_next  = val_reg;
        full_next = full_reg;
        if (ctrl.clear) begin
            full_next = 1'b0;
        end else if (ctrl.shift) begin
            val_next  = left_val;
            full_next = left_full;
        end else if (ctrl.insert && moves) begin
            if (left_moves) begin
                val_next  = left_val;
                full_next = left_full;
            end else begin
                val_next  = new_val;
                full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val  = val_reg;
    assign full = full_reg;
endmodule

// ===== src/tsq_sort_chain.sv =====
// A row of sorting cells. After a group is inserted, shifting drains the values
// out of the last cell in descending order.
module tsq_sort_chain #(
    parameter int N = tsq_pkg::SAMPLES_PER_AXIS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tsq_pkg::cell_ctrl_t          ctrl,
    input  logic [tsq_pkg::SAMPLE_W-1:0] new_val,
    output logic [tsq_pkg::SAMPLE_W-1:0] tail_val
);
    logic [tsq_pkg::SAMPLE_W-1:0] vals [N];
    logic [N-1:0]                 fulls;
    logic [N-1:0]                 moves;

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic [tsq_pkg::SAMPLE_W-1:0] lv;
        logic                         lf;
        logic                         lm;
        if (i == 0) begin : g_first
            assign lv = '0;
            assign lf = 1'b0;
            assign lm = 1'b0;
        end else begin : g_rest
            assign lv = vals[i-1];
            assign lf = fulls[i-1];
            assign lm = moves[i-1];
        end
        tsq_sort_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_val    (new_val),
            .left_val   (lv),
            .left_full  (lf),
            .left_moves (lm),
            .val        (vals[i]),
            .full       (fulls[i]),
            .moves      (moves[i])
        );
    end

    assign tail_val = vals[N-1];
endmodule

// ===== src/touch_sample_qualifier_unit.sv =====
// Touch sample qualifier: trimmed-mean filter for resistive touch samples.
// A sample beat that does not end a group is absorbed without a stall, so a group's samples
// may arrive back to back while no result beat waits on the output. A beat ending one of the
// first three groups stalls the input while the sorting chain drains and the mean is divided.
// The beat ending the fourth group shows its result after division and calibration; a pen-up
// beat shows it next cycle. Reset clears control and sets the configuration to its defaults.
module touch_sample_qualifier_unit #(
    parameter int SAMPLES_PER_AXIS = tsq_pkg::SAMPLES_PER_AXIS_DEF,
    parameter int TRIM_EACH_END    = tsq_pkg::TRIM_EACH_END_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [tsq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsq_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [tsq_pkg::SAMPLE_W-1:0]   sample,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tsq_pkg::POS_W-1:0]      x_pos,
    output logic [tsq_pkg::POS_W-1:0]      y_pos,
    output logic                           pressed,
    output logic                           new_press,
    output logic [tsq_pkg::POS_W-1:0]      start_x,
    output logic [tsq_pkg::POS_W-1:0]      start_y,
    output logic                           pair_agreed
);
    localparam int N         = SAMPLES_PER_AXIS;
    localparam int TRIM      = (2 * TRIM_EACH_END >= N) ? (N - 1) / 2 : TRIM_EACH_END;
    localparam int KEPT      = N - 2 * TRIM;
    localparam int CNT_W     = $clog2(N + 1);
    localparam int SUM_W     = tsq_pkg::SAMPLE_W + $clog2(N + 1);
    // Reciprocal for dividing the trimmed sum by KEPT: a multiply, then a
    // small correction step.
    localparam int RSH       = SUM_W + 2;
    localparam longint RECIP = ((64'd1 << RSH) / KEPT);
    localparam int RW        = RSH + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DRAIN = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_FIX   = 3'd3;
    localparam logic [2:0] ST_CAL   = 3'd4;
    localparam logic [2:0] ST_SAT   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // configuration
    logic                         raw_mode_reg;
    logic [tsq_pkg::SAMPLE_W-1:0] agree_range_reg;
    logic signed [15:0]           x_gain_reg, x_offset_reg, y_gain_reg, y_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            raw_mode_reg    <= 1'b0;
            agree_range_reg <= 12'd30;
            x_gain_reg      <= 16'sd4096;
            x_offset_reg    <= '0;
            y_gain_reg      <= 16'sd4096;
            y_offset_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                tsq_pkg::REG_RAW_MODE:    raw_mode_reg    <= cfg_data[0];
                tsq_pkg::REG_AGREE_RANGE: agree_range_reg <= cfg_data[11:0];
                tsq_pkg::REG_X_GAIN:      x_gain_reg      <= cfg_data;
                tsq_pkg::REG_X_OFFSET:    x_offset_reg    <= cfg_data;
                tsq_pkg::REG_Y_GAIN:      y_gain_reg      <= cfg_data;
                tsq_pkg::REG_Y_OFFSET:    y_offset_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // control and data state
    logic [2:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             pos_reg, pos_next;      // place within a group
    logic [1:0]                   phase_reg, phase_next;  // which of the four groups
    logic [CNT_W-1:0]             drain_reg, drain_next;
    logic [SUM_W-1:0]             sum_reg, sum_next;
    logic [SUM_W+RW-1:0]          prod_reg, prod_next;
    logic [tsq_pkg::SAMPLE_W:0]   quot_reg, quot_next;
    logic [tsq_pkg::SAMPLE_W-1:0] fx_reg, fx_next, fy_reg, fy_next, sx_reg, sx_next;
    logic [tsq_pkg::SAMPLE_W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic                         agreed_reg, agreed_next;
    logic signed [45:0]           vx_reg, vx_next, vy_reg, vy_next;
    logic [tsq_pkg::POS_W-1:0]    cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [tsq_pkg::POS_W-1:0]    px_reg, px_next, py_reg, py_next;
    logic                         pen_reg, pen_next;
    logic                         newp_reg, newp_next;
    logic                         ov_reg, ov_next;

    tsq_pkg::cell_ctrl_t          ctrl;
    logic [tsq_pkg::SAMPLE_W-1:0] tail_val;

    tsq_sort_chain #(.N(N)) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .new_val  (sample),
        .tail_val (tail_val)
    );

    logic accept;
    assign in_stall = (state_reg != ST_IDLE) || ov_reg;
    assign accept   = in_valid && !in_stall;

    function automatic logic close_f(input logic [11:0] a, input logic [11:0] b,
                                     input logic [11:0] r);
        logic [11:0] d;
        begin
            d = (a > b) ? a - b : b - a;
            close_f = d < r;
        end
    endfunction

    function automatic logic [15:0] sat_f(input logic signed [45:0] v);
        logic signed [45:0] q;
        begin
            q = v >>> 12;
            if (v < 0)
                sat_f = '0;
            else if (q > 46'sd65535)
                sat_f = 16'hFFFF;
            else
                sat_f = q[15:0];
        end
    endfunction

    logic [tsq_pkg::SAMPLE_W-1:0] mean;
    assign mean = quot_reg[tsq_pkg::SAMPLE_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        drain_next  = drain_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        quot_next   = quot_reg;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        sx_next     = sx_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        agreed_next = agreed_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        pen_next    = pen_reg;
        newp_next   = newp_reg;
        ov_next     = ov_reg && out_stall;
        ctrl        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    if (cmd) begin
                        // Pen up ends a press or marks no touch, and aborts a scan.
                        ctrl.clear  = 1'b1;
                        pos_next    = '0;
                        phase_next  = '0;
                        if (pen_reg) begin
                            pen_next = 1'b0;
                        end else begin
                            px_next    = '0;
                            py_next    = '0;
                            cur_x_next = tsq_pkg::NO_TOUCH;
                            cur_y_next = tsq_pkg::NO_TOUCH;
                        end
                        newp_next   = 1'b0;
                        agreed_next = 1'b0;
                        ov_next     = 1'b1;
                    end else begin
                        ctrl.insert = 1'b1;
                        if (pos_reg == CNT_W'(N - 1)) begin
                            pos_next   = '0;
                            drain_next = '0;
                            sum_next   = '0;
                            state_next = ST_DRAIN;
                        end else begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                // Values leave the tail largest first; keep the middle ones.
                ctrl.shift = 1'b1;
                if (drain_reg >= CNT_W'(TRIM) && drain_reg < CNT_W'(N - TRIM))
                    sum_next = sum_reg + SUM_W'(tail_val);
                drain_next = drain_reg + 1'b1;
                if (drain_reg == CNT_W'(N - 1)) begin
                    ctrl.shift = 1'b0;
                    ctrl.clear = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                prod_next  = (SUM_W+RW)'(sum_reg) * (SUM_W+RW)'(RECIP);
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                // Estimate may fall one short; correct with one compare.
                quot_next = (tsq_pkg::SAMPLE_W+1)'(prod_reg >> RSH);
                if ((SUM_W+RW)'(sum_reg) >=
                    (SUM_W+RW)'(quot_next + 1'b1) * (SUM_W+RW)'(KEPT))
                    quot_next = quot_next + 1'b1;
                if (phase_reg inside {2'd0, 2'd1, 2'd2})
                    state_next = ST_SAT;
                else
                    state_next = ST_CAL;
            end
            ST_CAL:
            begin
                agreed_next = close_f(fx_reg, sx_reg, agree_range_reg)
                           && close_f(fy_reg, mean, agree_range_reg);
                ax_next = 12'(({1'b0, fx_reg} + {1'b0, sx_reg}) >> 1);
                ay_next = 12'(({1'b0, fy_reg} + {1'b0, mean}) >> 1);
                vx_next = 46'(x_gain_reg * $signed({1'b0, ax_next}))
                        + 46'($signed({x_offset_reg, 12'b0}));
                vy_next = 46'(y_gain_reg * $signed({1'b0, ay_next}))
                        + 46'($signed({y_offset_reg, 12'b0}));
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                case (phase_reg)
                    2'd0: begin fx_next = mean; state_next = ST_IDLE; end
                    2'd1: begin fy_next = mean; state_next = ST_IDLE; end
                    2'd2: begin sx_next = mean; state_next = ST_IDLE; end
                    default:
                    begin
                        if (agreed_reg) begin
                            cur_x_next = raw_mode_reg ? 16'(ax_reg) : sat_f(vx_reg);
                            cur_y_next = raw_mode_reg ? 16'(ay_reg) : sat_f(vy_reg);
                        end
                        state_next = ST_OUT;
                    end
                endcase
                phase_next = phase_reg + 1'b1;
            end
            ST_OUT:
            begin
                newp_next = !pen_reg;
                if (!pen_reg) begin
                    pen_next = 1'b1;
                    px_next  = cur_x_reg;
                    py_next  = cur_y_reg;
                end
                ov_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            phase_reg  <= '0;
            drain_reg  <= '0;
            fx_reg     <= '0;
            fy_reg     <= '0;
            sx_reg     <= '0;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            pen_reg    <= 1'b0;
            newp_reg   <= 1'b0;
            agreed_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            drain_reg  <= drain_next;
            fx_reg     <= fx_next;
            fy_reg     <= fy_next;
            sx_reg     <= sx_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            pen_reg    <= pen_next;
            newp_reg   <= newp_next;
            agreed_reg <= agreed_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
    end

    // The result beat reads the state registers directly; they hold while the
    // beat waits because no input is taken until it leaves.
    assign out_valid   = ov_reg;
    assign x_pos       = cur_x_reg;
    assign y_pos       = cur_y_reg;
    assign pressed     = pen_reg;
    assign new_press   = newp_reg;
    assign start_x     = px_reg;
    assign start_y     = py_reg;
    assign pair_agreed = agreed_reg;
endmodule
